// ===== rtl/core/kmo_pkg.sv =====
// ----------------------------------------------------------------------------
// kmo_pkg - shared types and constants for the KST momentum oscillator
// Transaction payloads, divider request/response, sequencer states, register
// codes and reset values.
// ----------------------------------------------------------------------------
package kmo_pkg;

  // default storage depths
  localparam int DEF_MAX_LAG    = 255;
  localparam int DEF_MAX_WINDOW = 255;
  localparam int DEF_MAX_SIGNAL = 255;

  // fixed field widths
  localparam int PRICE_BITS = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 8;   // lags, window and signal lengths
  localparam int IW         = 13;  // compare width for lengths against depths
  localparam int DVD_W      = 64;  // divider dividend
  localparam int DSR_W      = 32;  // divider divisor
  localparam int RATE_W     = 32;  // Q16.16 rate
  localparam int SUM_W      = 40;  // sum of up to 255 rates
  localparam int CNT_W      = 9;
  localparam int WGT_W      = 16;
  localparam int KST_W      = 48;  // Q32.16
  localparam int ACC_W      = 50;  // Q26.24 weighted sum
  localparam int SSUM_W     = 56;  // sum of up to 255 KST values

  // register reset values
  localparam logic [CFG_W-1:0] RST_ROC_LAGS   = 32'h1E14_0F0A;
  localparam logic [CFG_W-1:0] RST_AVG_LENS   = 32'h0F0A_0A0A;
  localparam logic [WGT_W-1:0] RST_WEIGHT_1   = 16'd256;
  localparam logic [WGT_W-1:0] RST_WEIGHT_2   = 16'd512;
  localparam logic [WGT_W-1:0] RST_WEIGHT_3   = 16'd768;
  localparam logic [WGT_W-1:0] RST_WEIGHT_4   = 16'd1024;
  localparam logic [LEN_W-1:0] RST_SIGNAL_LEN = 8'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROC_LAGS   = 3'd0,
    CFG_AVG_LENS   = 3'd1,
    CFG_WEIGHT_1   = 3'd2,
    CFG_WEIGHT_2   = 3'd3,
    CFG_WEIGHT_3   = 3'd4,
    CFG_WEIGHT_4   = 3'd5,
    CFG_SIGNAL_LEN = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] price;
    logic        price_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [KST_W-1:0] kst_value;
    logic                    kst_ok;
    logic signed [KST_W-1:0] signal_value;
    logic                    signal_ok;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_HIST,
    ST_CHK_HIST,
    ST_DIV_ROC,
    ST_WR_WIN,
    ST_SCAN,
    ST_AVG,
    ST_DIV_AVG,
    ST_NEXT_K,
    ST_MUL,
    ST_MACC,
    ST_KST,
    ST_SSCAN,
    ST_SDIV,
    ST_SDIV_W,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/kmo_div.sv =====
// ----------------------------------------------------------------------------
// kmo_div - shared radix-2 restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle; done pulses
// once the last bit is in the quotient register.
// ----------------------------------------------------------------------------
module kmo_div (
  input  logic               clk,
  input  logic               rst_n,
  input  kmo_pkg::div_req_t  req,
  output kmo_pkg::div_rsp_t  rsp
);
  import kmo_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DSR_W:0]    trial_c;
  logic              take_c;

  assign trial_c = {rem_r, quo_r[DVD_W-1]};
  assign take_c  = trial_c >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= take_c ? DSR_W'(trial_c - {1'b0, dsr_r}) : DSR_W'(trial_c);
      quo_r <= {quo_r[DVD_W-2:0], take_c};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/core/kst_momentum_oscillator.sv =====
// ----------------------------------------------------------------------------
// kst_momentum_oscillator - Know Sure Thing oscillator with signal line
// One price per transaction in, one KST/signal result per transaction out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in_     | sink      | in_valid / in_stall | in_item_t  (price, flag)
//  out_    | source    | out_valid/out_stall | out_item_t (kst, signal)
//  cfg_    | sink      | cfg_we              | cfg_idx, cfg_wdata
//
//  Nine passes through the shared divider dominate a transaction; a rate
//  that is invalid or saturates skips its pass, as does an invalid average,
//  and the signal pass runs only when all four averages are valid and the
//  signal window is full.
//  in_stall is high from acceptance until the result is loaded into the
//  output register; the next price is taken while that result waits.
//  Reset (rst_n low, synchronous) clears pointers, fill counts, state, config
//  and output valid; history memories need no clearing, reads stay in a fill.
//
module kst_momentum_oscillator #(
  parameter int MAX_LAG    = kmo_pkg::DEF_MAX_LAG,
  parameter int MAX_WINDOW = kmo_pkg::DEF_MAX_WINDOW,
  parameter int MAX_SIGNAL = kmo_pkg::DEF_MAX_SIGNAL
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  kmo_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output kmo_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [kmo_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [kmo_pkg::CFG_W-1:0]        cfg_wdata
);
  import kmo_pkg::*;

  localparam int HIST_DEPTH = MAX_LAG + 1;
  localparam int HAW        = $clog2(HIST_DEPTH);
  localparam int ITEMS_W    = $clog2(HIST_DEPTH + 1);
  localparam int WAW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WFILL_W    = $clog2(MAX_WINDOW + 1);
  localparam int SAW        = (MAX_SIGNAL > 1) ? $clog2(MAX_SIGNAL) : 1;
  localparam int SFILL_W    = $clog2(MAX_SIGNAL + 1);

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0]        roc_lags_r;
  logic [CFG_W-1:0]        avg_lens_r;
  logic signed [WGT_W-1:0] weight_r [4];
  logic [LEN_W-1:0]        signal_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roc_lags_r   <= RST_ROC_LAGS;
      avg_lens_r   <= RST_AVG_LENS;
      weight_r[0]  <= RST_WEIGHT_1;
      weight_r[1]  <= RST_WEIGHT_2;
      weight_r[2]  <= RST_WEIGHT_3;
      weight_r[3]  <= RST_WEIGHT_4;
      signal_len_r <= RST_SIGNAL_LEN;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROC_LAGS:   roc_lags_r   <= cfg_wdata;
        CFG_AVG_LENS:   avg_lens_r   <= cfg_wdata;
        CFG_WEIGHT_1:   weight_r[0]  <= cfg_wdata[WGT_W-1:0];
        CFG_WEIGHT_2:   weight_r[1]  <= cfg_wdata[WGT_W-1:0];
        CFG_WEIGHT_3:   weight_r[2]  <= cfg_wdata[WGT_W-1:0];
        CFG_WEIGHT_4:   weight_r[3]  <= cfg_wdata[WGT_W-1:0];
        CFG_SIGNAL_LEN: signal_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  // captured transaction
  logic [PRICE_BITS-1:0] price_r;
  logic                  pv_r;
  logic [HAW-1:0]        cur_r;
  logic [ITEMS_W-1:0]    before_r;

  // price history
  logic [PRICE_BITS:0]   hist_mem [HIST_DEPTH];
  logic [PRICE_BITS:0]   hist_rd_r;
  logic [HAW-1:0]        hist_wp_r;
  logic [ITEMS_W-1:0]    items_r;

  // rate windows, one region of the memory per rate
  logic [RATE_W:0]       win_mem [4 << WAW];
  logic [RATE_W:0]       win_rd_r;
  logic [WAW-1:0]        win_wp_r [4];
  logic [WFILL_W-1:0]    win_fill_r [4];
  logic [WAW-1:0]        wscan_ptr_r;

  // KST history
  logic [KST_W-1:0]      kst_mem [1 << SAW];
  logic [KST_W-1:0]      kst_rd_r;
  logic [SAW-1:0]        kst_wp_r;
  logic [SFILL_W-1:0]    kst_fill_r;
  logic [SAW-1:0]        sscan_ptr_r;

  // working registers
  logic [1:0]               k_r;
  logic                     neg_r;
  logic signed [RATE_W-1:0] rate_val_r;
  logic                     rate_ok_r;
  logic [LEN_W-1:0]         left_r;
  logic                     rd_v_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [RATE_W-1:0] avg_r [4];
  logic                     all_ok_r;
  logic signed [KST_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [KST_W-1:0]  kst_r;
  logic signed [SSUM_W-1:0] ssum_r;
  logic [LEN_W-1:0]         slen_r;
  logic signed [KST_W-1:0]  sig_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  kmo_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------- datapath
  logic                      in_acc_c;
  logic                      load_out_c;
  logic [LEN_W-1:0]          lag_raw_c, len_raw_c;
  logic [IW-1:0]             lag_c, cur_ext_c;
  logic [HAW-1:0]            hist_raddr_c;
  logic [PRICE_BITS-1:0]     old_price_c, mag_c;
  logic                      roc_ok_c, neg_c, ovf_c;
  logic [38:0]               num_c;
  logic [LEN_W-1:0]          len_c;
  logic [WFILL_W-1:0]        wfill_nxt_c;
  logic                      win_full_c;
  logic [SUM_W-1:0]          sum_mag_c;
  logic [RATE_W-1:0]         q32_c;
  logic signed [KST_W-1:0]   prod_c;
  logic signed [ACC_W-1:0]   acc_adj_c;
  logic signed [ACC_W-1:0]   acc_sh_c;
  logic signed [KST_W-1:0]   kst_c;
  logic [LEN_W-1:0]          slen_c;
  logic [SFILL_W-1:0]        kfill_nxt_c;
  logic                      sig_full_c;
  logic [SSUM_W-1:0]         ssum_mag_c;
  logic [KST_W-1:0]          q48_c;

  assign in_acc_c   = in_valid && !in_stall;
  assign load_out_c = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // lag k, clamped, and the history slot that it points back to
  assign lag_raw_c = roc_lags_r[8*k_r +: 8];
  assign lag_c     = (IW'(lag_raw_c) > IW'(MAX_LAG)) ? IW'(MAX_LAG) : IW'(lag_raw_c);
  assign cur_ext_c = IW'(cur_r);
  assign hist_raddr_c = (cur_ext_c >= lag_c) ? HAW'(cur_ext_c - lag_c)
                                             : HAW'(cur_ext_c + IW'(HIST_DEPTH) - lag_c);

  // percent rate: 100*|now-old|*2^16/old, saturated when the quotient
  // would reach 2^31
  assign old_price_c = hist_rd_r[PRICE_BITS-1:0];
  assign roc_ok_c    = pv_r && (IW'(before_r) >= lag_c) && hist_rd_r[PRICE_BITS]
                       && (old_price_c != '0);
  assign neg_c = price_r < old_price_c;
  assign mag_c = neg_c ? (old_price_c - price_r) : (price_r - old_price_c);
  assign num_c = 39'(mag_c) * 39'd100;
  assign ovf_c = 47'(num_c) >= {old_price_c, 15'd0};

  // window length, clamped, and whether the window is full after this entry
  assign len_raw_c   = avg_lens_r[8*k_r +: 8];
  assign len_c       = (IW'(len_raw_c) > IW'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : len_raw_c;
  assign wfill_nxt_c = (win_fill_r[k_r] == WFILL_W'(MAX_WINDOW)) ? win_fill_r[k_r]
                                                                 : win_fill_r[k_r] + 1'b1;
  assign win_full_c  = (IW'(wfill_nxt_c) >= IW'(len_c)) && (len_c != '0);

  assign sum_mag_c = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign q32_c     = div_rsp.quotient[RATE_W-1:0];

  assign prod_c = weight_r[k_r] * avg_r[k_r];

  // Q26.24 to Q32.16, truncating toward zero
  assign acc_adj_c = acc_r + (acc_r[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
  assign acc_sh_c  = acc_adj_c >>> 8;
  assign kst_c     = KST_W'(acc_sh_c);

  // signal length: zero acts as one, clamp to depth
  always_comb begin
    slen_c = signal_len_r;
    if (signal_len_r == '0) slen_c = LEN_W'(1);
    else if (IW'(signal_len_r) > IW'(MAX_SIGNAL)) slen_c = LEN_W'(MAX_SIGNAL);
  end
  assign kfill_nxt_c = (kst_fill_r == SFILL_W'(MAX_SIGNAL)) ? kst_fill_r : kst_fill_r + 1'b1;
  assign sig_full_c  = IW'(kfill_nxt_c) >= IW'(slen_c);
  assign ssum_mag_c  = ssum_r[SSUM_W-1] ? SSUM_W'(-ssum_r) : SSUM_W'(ssum_r);
  assign q48_c       = div_rsp.quotient[KST_W-1:0];

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (in_acc_c) hist_mem[hist_wp_r] <= {in_data.price_valid, in_data.price};
    hist_rd_r <= hist_mem[hist_raddr_c];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WR_WIN) win_mem[{k_r, win_wp_r[k_r]}] <= {rate_ok_r, rate_val_r};
    win_rd_r <= win_mem[{k_r, wscan_ptr_r}];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_KST) kst_mem[kst_wp_r] <= kst_c;
    kst_rd_r <= kst_mem[sscan_ptr_r];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = 64'({num_c, 16'd0});
    div_req.divisor  = old_price_c;
    unique case (state_r)
      ST_IDLE:     if (in_acc_c) state_nxt = ST_RD_HIST;
      ST_RD_HIST:  state_nxt = ST_CHK_HIST;
      ST_CHK_HIST: begin
        if (roc_ok_c && !ovf_c) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_ROC;
        end else begin
          state_nxt = ST_WR_WIN;
        end
      end
      ST_DIV_ROC:  if (div_rsp.done) state_nxt = ST_WR_WIN;
      ST_WR_WIN:   state_nxt = win_full_c ? ST_SCAN : ST_AVG;
      ST_SCAN:     if (left_r == '0 && !rd_v_r) state_nxt = ST_AVG;
      ST_AVG: begin
        div_req.dividend = DVD_W'(sum_mag_c);
        div_req.divisor  = DSR_W'(cnt_r);
        if (cnt_r != '0) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_AVG;
        end else begin
          state_nxt = ST_NEXT_K;
        end
      end
      ST_DIV_AVG:  if (div_rsp.done) state_nxt = ST_NEXT_K;
      ST_NEXT_K: begin
        if (k_r != 2'd3)   state_nxt = ST_RD_HIST;
        else if (all_ok_r) state_nxt = ST_MUL;
        else               state_nxt = ST_DONE;
      end
      ST_MUL:      state_nxt = ST_MACC;
      ST_MACC:     state_nxt = (k_r == 2'd3) ? ST_KST : ST_MUL;
      ST_KST:      state_nxt = sig_full_c ? ST_SSCAN : ST_DONE;
      ST_SSCAN:    if (left_r == '0 && !rd_v_r) state_nxt = ST_SDIV;
      ST_SDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(ssum_mag_c);
        div_req.divisor  = DSR_W'(slen_r);
        state_nxt        = ST_SDIV_W;
      end
      ST_SDIV_W:   if (div_rsp.done) state_nxt = ST_DONE;
      ST_DONE:     if (load_out_c) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // pointers, fill counts and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_wp_r   <= '0;
      items_r     <= '0;
      kst_wp_r    <= '0;
      kst_fill_r  <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        win_wp_r[i]   <= '0;
        win_fill_r[i] <= '0;
      end
    end else begin
      if (in_acc_c) begin
        hist_wp_r <= (hist_wp_r == HAW'(HIST_DEPTH - 1)) ? '0 : hist_wp_r + 1'b1;
        if (items_r != ITEMS_W'(HIST_DEPTH)) items_r <= items_r + 1'b1;
      end
      if (state_r == ST_WR_WIN) begin
        win_wp_r[k_r]   <= (win_wp_r[k_r] == WAW'(MAX_WINDOW - 1)) ? '0 : win_wp_r[k_r] + 1'b1;
        win_fill_r[k_r] <= wfill_nxt_c;
      end
      if (state_r == ST_KST) begin
        kst_wp_r   <= (kst_wp_r == SAW'(MAX_SIGNAL - 1)) ? '0 : kst_wp_r + 1'b1;
        kst_fill_r <= kfill_nxt_c;
      end
      // read issued this cycle returns data next cycle
      rd_v_r <= ((state_r == ST_SCAN) || (state_r == ST_SSCAN)) && (left_r != '0);
      if (load_out_c)                  out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc_c) begin
      price_r  <= in_data.price;
      pv_r     <= in_data.price_valid;
      cur_r    <= hist_wp_r;
      before_r <= items_r;
      k_r      <= '0;
      all_ok_r <= 1'b1;
    end
    unique case (state_r)
      ST_CHK_HIST: begin
        neg_r      <= neg_c;
        rate_ok_r  <= roc_ok_c;
        // saturate when the quotient would overflow, else clear for the divider
        rate_val_r <= !(roc_ok_c && ovf_c) ? '0 :
                      neg_c ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      ST_DIV_ROC:
        if (div_rsp.done) rate_val_r <= neg_r ? -$signed(q32_c) : $signed(q32_c);
      ST_WR_WIN: begin
        left_r      <= win_full_c ? len_c : '0;
        wscan_ptr_r <= win_wp_r[k_r];
        sum_r       <= '0;
        cnt_r       <= '0;
      end
      ST_SCAN: begin
        if (left_r != '0) begin
          left_r      <= left_r - 1'b1;
          wscan_ptr_r <= (wscan_ptr_r == '0) ? WAW'(MAX_WINDOW - 1) : wscan_ptr_r - 1'b1;
        end
        if (rd_v_r && win_rd_r[RATE_W]) begin
          sum_r <= sum_r + SUM_W'($signed(win_rd_r[RATE_W-1:0]));
          cnt_r <= cnt_r + 1'b1;
        end
      end
      ST_AVG:
        if (cnt_r == '0) begin
          avg_r[k_r] <= '0;
          all_ok_r   <= 1'b0;
        end
      ST_DIV_AVG:
        if (div_rsp.done) avg_r[k_r] <= sum_r[SUM_W-1] ? -$signed(q32_c) : $signed(q32_c);
      ST_NEXT_K: begin
        k_r   <= k_r + 1'b1;  // wraps to zero for the weighting pass
        acc_r <= '0;
        kst_r <= '0;
        sig_r <= '0;
      end
      ST_MUL:  prod_r <= prod_c;
      ST_MACC: begin
        acc_r <= acc_r + ACC_W'(prod_r);
        k_r   <= k_r + 1'b1;
      end
      ST_KST: begin
        kst_r       <= kst_c;
        sig_r       <= kst_c;  // warm-up: signal follows the KST
        slen_r      <= slen_c;
        left_r      <= sig_full_c ? slen_c : '0;
        sscan_ptr_r <= kst_wp_r;
        ssum_r      <= '0;
      end
      ST_SSCAN: begin
        if (left_r != '0) begin
          left_r      <= left_r - 1'b1;
          sscan_ptr_r <= (sscan_ptr_r == '0) ? SAW'(MAX_SIGNAL - 1) : sscan_ptr_r - 1'b1;
        end
        if (rd_v_r) ssum_r <= ssum_r + SSUM_W'($signed(kst_rd_r));
      end
      ST_SDIV_W:
        if (div_rsp.done) sig_r <= ssum_r[SSUM_W-1] ? -$signed(q48_c) : $signed(q48_c);
      ST_DONE:
        if (load_out_c) begin
          out_data_r.kst_value    <= kst_r;
          out_data_r.kst_ok       <= all_ok_r;
          out_data_r.signal_value <= sig_r;
          out_data_r.signal_ok    <= all_ok_r;
        end
      default: ;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/kmo_checker.sv =====
// ----------------------------------------------------------------------------
// kmo_checker - port-level checks for the KST momentum oscillator
// Bound to the top level; watches handshakes and result consistency.
// ----------------------------------------------------------------------------
module kmo_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input kmo_pkg::out_item_t            out_data
);
  import kmo_pkg::*;

  // one transaction at a time: the port closes after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in progress");

  a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kst_ok == out_data.signal_ok))
    else $error("kst_ok and signal_ok differ");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.kst_ok) |->
      (out_data.kst_value == '0 && out_data.signal_value == '0))
    else $error("invalid result carries nonzero values");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

endmodule

bind kst_momentum_oscillator kmo_checker u_kmo_checker (.*);
